// File: design/hjbp_pkg.sv
`default_nettype none
package hjbp_pkg;

  localparam int BUCKETS_DEF     = 1024;
  localparam int ENTRIES_DEF     = 4096;
  localparam int MAX_MATCHES_DEF = 64;

  localparam int KEY_W = 32;
  localparam int OFF_W = 24;
  localparam int CNT_W = 11;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_PROBE = 2'd2
  } cmd_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_POOL_FULL = 2'd1;
  localparam logic [1:0] ST_TRUNC     = 2'd2;

  localparam logic [0:0] KIND_ACK   = 1'b0;
  localparam logic [0:0] KIND_MATCH = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_MOD,
    S_BKT_RD,
    S_BKT_WAIT,
    S_BUILD,
    S_PROBE_RD,
    S_PROBE_WAIT,
    S_PROBE_CHK,
    S_FLUSH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request, start modulo
    logic mod_step;   // one restoring-division step
    logic clr_step;   // clear one bucket mark, advance sweep
    logic clr_start;  // reset sweep pointer and counters
    logic bkt_rd;     // read bucket memories at computed bucket
    logic build_wr;   // write entry, link chain, emit ack
    logic ent_rd;     // read entry at walk pointer
    logic ent_chk;    // compare key, maybe emit match, advance
    logic flush;      // emit held match as final
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic mod_done;
    logic clr_done;
    logic used;       // bucket mark of looked-up bucket
    logic at_tail;    // walk pointer equals tail
    logic hit;        // key at walk pointer matches
    logic hold_valid; // a match is held back awaiting the next one
    logic cap_full;   // MAX_MATCHES already emitted
  } sts_t;

endpackage
`default_nettype wire

// File: design/hash_join_build_probe_unit.sv
`default_nettype none
// Hash join build/probe engine. Pulse start with command, join_key and
// payload_offset while busy is low. After reset the block sweeps its bucket
// marks with busy high. A build runs a restoring modulo of the key by
// bucket_count, a bucket read, a read wait and a pool write; its one
// acknowledgement comes in the cycle busy falls. A probe runs the same steps
// up to the read wait, then, if the bucket is used, a read, a wait and a
// check per chain entry walked and a flush at the tail; matches come out one
// per strobe as the walk proceeds, the receiver cannot stall them. A clear
// sweeps the bucket marks, one per cycle. bucket_count is written over APB
// at address 0, by the user only while idle; the block does not enforce it.
module hash_join_build_probe_unit
  import hjbp_pkg::*;
#(
  parameter int BUCKETS     = BUCKETS_DEF,
  parameter int ENTRIES     = ENTRIES_DEF,
  parameter int MAX_MATCHES = MAX_MATCHES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       command,
  input  wire logic [KEY_W-1:0] join_key,
  input  wire logic [OFF_W-1:0] payload_offset,
  output logic                  result_valid,
  output logic [0:0]            kind,
  output logic [1:0]            status,
  output logic [OFF_W-1:0]      matched_offset,
  output logic [KEY_W-1:0]      matched_key,
  output logic                  last,
  output logic [KEY_W-1:0]      join_total,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [1:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  ctl_t           ctl;
  sts_t           sts;
  logic [CNT_W-1:0] bucket_count;

  // config register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) bucket_count <= CNT_W'(1023);
    else if (psel && penable && pwrite && paddr == 2'd0) bucket_count <= pwdata[CNT_W-1:0];
  end
  assign prdata = (paddr == 2'd0) ? {21'd0, bucket_count} : 32'd0;

  hjbp_ctrl u_ctrl (
    .clk, .rst, .start, .command, .busy, .ctl, .sts
  );

  hjbp_dpath #(
    .BUCKETS(BUCKETS), .ENTRIES(ENTRIES), .MAX_MATCHES(MAX_MATCHES)
  ) u_dpath (
    .clk, .rst, .join_key, .payload_offset, .bucket_count, .ctl, .sts,
    .result_valid, .kind, .status, .matched_offset, .matched_key, .last,
    .join_total
  );

endmodule
`default_nettype wire

// File: design/hjbp_ctrl.sv
`default_nettype none
module hjbp_ctrl
  import hjbp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [1:0] command,
  output logic            busy,
  output ctl_t            ctl,
  input  sts_t            sts
);

  state_t state, state_next;
  logic   is_build;
  logic   is_build_next;

  // state register; reset enters the bucket mark sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      is_build <= 1'b0;
    end else begin
      state    <= state_next;
      is_build <= is_build_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    is_build_next = is_build;
    ctl           = '0;
    busy          = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (command) inside
            CMD_CLEAR: begin
              ctl.clr_start = 1'b1;
              state_next    = S_CLEAR;
            end
            CMD_BUILD, CMD_PROBE: begin
              ctl.load      = 1'b1;
              is_build_next = (command == CMD_BUILD);
              state_next    = S_MOD;
            end
            default: ;
          endcase
        end
      end
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_MOD: begin
        ctl.mod_step = 1'b1;
        if (sts.mod_done) state_next = S_BKT_RD;
      end
      S_BKT_RD: begin
        ctl.bkt_rd = 1'b1;
        state_next = S_BKT_WAIT;
      end
      S_BKT_WAIT: begin
        if (is_build)      state_next = S_BUILD;
        else if (sts.used) state_next = S_PROBE_RD;
        else               state_next = S_IDLE;
      end
      S_BUILD: begin
        ctl.build_wr = 1'b1;
        state_next   = S_IDLE;
      end
      S_PROBE_RD: begin
        ctl.ent_rd = 1'b1;
        state_next = S_PROBE_WAIT;
      end
      S_PROBE_WAIT: begin
        state_next = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        ctl.ent_chk = 1'b1;
        if (sts.hit && sts.cap_full) state_next = S_IDLE;
        else if (sts.at_tail)        state_next = S_FLUSH;
        else                         state_next = S_PROBE_RD;
      end
      S_FLUSH: begin
        ctl.flush  = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: design/hjbp_dpath.sv
`default_nettype none
module hjbp_dpath
  import hjbp_pkg::*;
#(
  parameter int BUCKETS     = BUCKETS_DEF,
  parameter int ENTRIES     = ENTRIES_DEF,
  parameter int MAX_MATCHES = MAX_MATCHES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [KEY_W-1:0] join_key,
  input  wire logic [OFF_W-1:0] payload_offset,
  input  wire logic [CNT_W-1:0] bucket_count,
  input  ctl_t                  ctl,
  output sts_t                  sts,
  output logic                  result_valid,
  output logic [0:0]            kind,
  output logic [1:0]            status,
  output logic [OFF_W-1:0]      matched_offset,
  output logic [KEY_W-1:0]      matched_key,
  output logic                  last,
  output logic [KEY_W-1:0]      join_total
);

  localparam int BW  = $clog2(BUCKETS);
  localparam int EW  = $clog2(ENTRIES);
  localparam int ECW = $clog2(ENTRIES + 1);
  localparam int DW  = $clog2(BUCKETS + 1);
  localparam int MW  = $clog2(MAX_MATCHES + 1);
  localparam int SW  = $clog2(KEY_W + 1);

  // memories
  logic [EW-1:0]    head_mem [BUCKETS];
  logic [EW-1:0]    tail_mem [BUCKETS];
  logic             used_mem [BUCKETS];
  logic [KEY_W-1:0] key_mem  [ENTRIES];
  logic [OFF_W-1:0] pay_mem  [ENTRIES];
  logic [EW-1:0]    next_mem [ENTRIES];

  // request registers
  logic [KEY_W-1:0] key_q;
  logic [OFF_W-1:0] off_q;
  logic [DW-1:0]    divisor;
  logic [DW-1:0]    rem;
  logic [KEY_W-1:0] quo_sh;
  logic [SW-1:0]    mod_cnt;
  logic [BW-1:0]    bucket;

  logic [ECW-1:0]   entries_used;
  logic [KEY_W-1:0] match_total;
  logic [BW:0]      clr_ptr;

  logic             used_rd;
  logic [EW-1:0]    head_rd, tail_rd;
  logic [EW-1:0]    walk;
  logic [KEY_W-1:0] ekey_rd;
  logic [OFF_W-1:0] epay_rd;
  logic [EW-1:0]    enext_rd;
  logic [MW-1:0]    n_emit;
  logic             hold_v;
  logic [OFF_W-1:0] hold_off;

  logic [DW:0]      rem_sh;
  logic [DW-1:0]    div_eff;

  // saturated divisor
  always_comb begin
    div_eff = DW'(bucket_count);
    if (bucket_count == '0) div_eff = DW'(1);
    else if (32'(bucket_count) > 32'(BUCKETS)) div_eff = DW'(BUCKETS);
  end

  // one restoring step: shift in next key bit, subtract if possible
  assign rem_sh = {rem, quo_sh[KEY_W-1]};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_q   <= join_key;
      off_q   <= payload_offset;
      quo_sh  <= join_key;
      rem     <= '0;
      mod_cnt <= '0;
      divisor <= div_eff;
    end else if (ctl.mod_step) begin
      quo_sh  <= {quo_sh[KEY_W-2:0], 1'b0};
      mod_cnt <= mod_cnt + SW'(1);
      if (rem_sh >= {1'b0, divisor}) rem <= DW'(rem_sh - {1'b0, divisor});
      else                           rem <= DW'(rem_sh);
    end
  end

  assign bucket = BW'(rem);

  // bucket marks: cleared by a sweep, set by a build
  always_ff @(posedge clk) begin
    if (ctl.clr_step && !clr_ptr[BW]) used_mem[clr_ptr[BW-1:0]] <= 1'b0;
    else if (ctl.build_wr && entries_used < ECW'(ENTRIES)) used_mem[bucket] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (ctl.bkt_rd) begin
      used_rd <= used_mem[bucket];
      head_rd <= head_mem[bucket];
      tail_rd <= tail_mem[bucket];
    end
  end

  // head/tail writes on build
  always_ff @(posedge clk) begin
    if (ctl.build_wr && entries_used < ECW'(ENTRIES)) begin
      tail_mem[bucket] <= EW'(entries_used);
      if (!used_rd) head_mem[bucket] <= EW'(entries_used);
    end
  end

  // entry pool: key/payload written at new entry, link written at old tail
  always_ff @(posedge clk) begin
    if (ctl.build_wr && entries_used < ECW'(ENTRIES)) begin
      key_mem[EW'(entries_used)] <= key_q;
      pay_mem[EW'(entries_used)] <= off_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.build_wr && entries_used < ECW'(ENTRIES) && used_rd)
      next_mem[tail_rd] <= EW'(entries_used);
  end

  always_ff @(posedge clk) begin
    if (ctl.ent_rd) begin
      ekey_rd  <= key_mem[walk];
      epay_rd  <= pay_mem[walk];
      enext_rd <= next_mem[walk];
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_used <= '0;
      match_total  <= '0;
      clr_ptr      <= '0;
      hold_v       <= 1'b0;
      n_emit       <= '0;
    end else begin
      if (ctl.clr_start) begin
        entries_used <= '0;
        match_total  <= '0;
        clr_ptr      <= '0;
      end else if (ctl.clr_step && !clr_ptr[BW]) begin
        clr_ptr <= clr_ptr + (BW+1)'(1);
      end
      if (ctl.build_wr && entries_used < ECW'(ENTRIES))
        entries_used <= entries_used + ECW'(1);
      if (ctl.load) begin
        hold_v <= 1'b0;
        n_emit <= '0;
      end
      if (ctl.ent_chk && sts.hit && !sts.cap_full) begin
        hold_v <= 1'b1;
        n_emit <= n_emit + MW'(1);
        if (match_total != '1) match_total <= match_total + KEY_W'(1);
      end
      if (ctl.flush || (ctl.ent_chk && sts.hit && sts.cap_full)) hold_v <= 1'b0;
    end
  end

  // bucket read data is back in the cycle after the read
  logic bkt_wait_q;
  always_ff @(posedge clk) begin
    if (rst) bkt_wait_q <= 1'b0;
    else     bkt_wait_q <= ctl.bkt_rd;
  end

  // walk pointer starts at the bucket head, then follows the links
  always_ff @(posedge clk) begin
    if (bkt_wait_q)       walk <= head_rd;
    else if (ctl.ent_chk) walk <= enext_rd;
    if (ctl.ent_chk && sts.hit && !sts.cap_full) hold_off <= epay_rd;
  end

  logic [EW-1:0] walk_cur;
  assign walk_cur = walk;

  // status
  assign sts.mod_done   = (mod_cnt == SW'(KEY_W - 1)) && ctl.mod_step;
  assign sts.clr_done   = clr_ptr[BW] || (clr_ptr == (BW+1)'(BUCKETS - 1));
  assign sts.used       = used_rd;
  assign sts.at_tail    = (walk_cur == tail_rd);
  assign sts.hit        = (ekey_rd == key_q);
  assign sts.hold_valid = hold_v;
  assign sts.cap_full   = (n_emit == MW'(MAX_MATCHES));

  // results; a match is held back until the next one or the flush so last and truncation can be marked
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (ctl.build_wr) begin
        result_valid   <= 1'b1;
        kind           <= KIND_ACK;
        status         <= (entries_used < ECW'(ENTRIES)) ? ST_OK : ST_POOL_FULL;
        matched_offset <= off_q;
        matched_key    <= key_q;
        last           <= 1'b1;
        join_total     <= match_total;
      end else if (ctl.ent_chk && sts.hit && hold_v) begin
        result_valid   <= 1'b1;
        kind           <= KIND_MATCH;
        status         <= sts.cap_full ? ST_TRUNC : ST_OK;
        matched_offset <= hold_off;
        matched_key    <= key_q;
        last           <= sts.cap_full;
        join_total     <= match_total;
      end else if (ctl.flush && hold_v) begin
        result_valid   <= 1'b1;
        kind           <= KIND_MATCH;
        status         <= ST_OK;
        matched_offset <= hold_off;
        matched_key    <= key_q;
        last           <= 1'b1;
        join_total     <= match_total;
      end
    end
  end

endmodule
`default_nettype wire

// File: bench/hash_join_build_probe_unit_test.sv
`timescale 1ns / 100ps

import hjbp_pkg::*;

typedef struct {
  logic [0:0]  kind;
  logic [1:0]  status;
  logic [23:0] offset;
  logic [31:0] key;
  logic        last;
  logic [31:0] total;
} join_result_t;

// Table model plus queue of results still owed by the block
class join_scoreboard;
  logic [10:0]  bucket_reg;
  bit           bkt_used[BUCKETS_DEF];
  int unsigned  bkt_head[BUCKETS_DEF];
  int unsigned  bkt_tail[BUCKETS_DEF];
  logic [31:0]  ent_key[ENTRIES_DEF];
  logic [23:0]  ent_off[ENTRIES_DEF];
  int unsigned  ent_next[ENTRIES_DEF];
  int unsigned  pool_fill;
  logic [31:0]  joins;
  join_result_t owed[$];

  function new();
    bucket_reg = 11'd1023;
    pool_fill = 0;
    joins = 0;
    foreach (bkt_used[i]) bkt_used[i] = 0;
  endfunction

  function int unsigned bucket_of(logic [31:0] key);
    int unsigned d;
    d = bucket_reg;
    if (d == 0) d = 1;
    if (d > BUCKETS_DEF) d = BUCKETS_DEF;
    return key % d;
  endfunction

  function join_result_t make(logic [0:0] k, logic [1:0] s, logic [23:0] o,
                              logic [31:0] key, logic l);
    join_result_t r;
    r.kind = k; r.status = s; r.offset = o; r.key = key; r.last = l; r.total = joins;
    return r;
  endfunction

  // accepted request: update table, queue expected results
  function void note_request(logic [1:0] cmd, logic [31:0] key, logic [23:0] off);
    int unsigned b, idx, e, n;
    join_result_t hits[$];
    b = bucket_of(key);
    case (cmd)
      CMD_CLEAR: begin
        foreach (bkt_used[i]) bkt_used[i] = 0;
        pool_fill = 0;
        joins = 0;
      end
      CMD_BUILD: begin
        if (pool_fill >= ENTRIES_DEF) begin
          owed.push_back(make(KIND_ACK, ST_POOL_FULL, off, key, 1'b1));
        end else begin
          e = pool_fill;
          ent_key[e] = key;
          ent_off[e] = off;
          ent_next[e] = 0;
          if (bkt_used[b]) ent_next[bkt_tail[b]] = e;
          else begin
            bkt_used[b] = 1;
            bkt_head[b] = e;
          end
          bkt_tail[b] = e;
          pool_fill = e + 1;
          owed.push_back(make(KIND_ACK, ST_OK, off, key, 1'b1));
        end
      end
      CMD_PROBE: begin
        if (bkt_used[b]) begin
          idx = bkt_head[b];
          n = 0;
          for (int s = 0; s < ENTRIES_DEF; s++) begin
            if (ent_key[idx] == key) begin
              if (n >= MAX_MATCHES_DEF) begin
                hits[n-1].status = ST_TRUNC;
                break;
              end
              if (joins != 32'hFFFF_FFFF) joins++;
              hits.push_back(make(KIND_MATCH, ST_OK, ent_off[idx], key, 1'b0));
              n++;
            end
            if (idx == bkt_tail[b]) break;
            idx = ent_next[idx];
          end
          if (n > 0) hits[n-1].last = 1'b1;
          foreach (hits[i]) owed.push_back(hits[i]);
        end
      end
      default: ;  // unused code: ignored
    endcase
  endfunction

  // returns empty string on a match, else a description
  function string check_result(join_result_t got);
    join_result_t w;
    if (owed.size() == 0) return "result with nothing expected";
    w = owed.pop_front();
    if (got.kind !== w.kind) return $sformatf("kind %0d exp %0d", got.kind, w.kind);
    if (got.status !== w.status)
      return $sformatf("status %0d exp %0d", got.status, w.status);
    if (got.offset !== w.offset)
      return $sformatf("offset %h exp %h", got.offset, w.offset);
    if (got.key !== w.key) return $sformatf("key %h exp %h", got.key, w.key);
    if (got.last !== w.last) return $sformatf("last %0d exp %0d", got.last, w.last);
    if (got.total !== w.total)
      return $sformatf("join_total %0d exp %0d", got.total, w.total);
    return "";
  endfunction
endclass

module hash_join_build_probe_unit_test;
  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic [1:0]  command = '0;
  logic [31:0] join_key = '0;
  logic [23:0] payload_offset = '0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire         busy, result_valid, last, pready;
  wire [0:0]   kind;
  wire [1:0]   status;
  wire [23:0]  matched_offset;
  wire [31:0]  matched_key, join_total, prdata;

  join_scoreboard table_sb = new();
  int          fail_count = 0;
  bit          quiet = 0;
  logic [31:0] key_pool[16];

  hash_join_build_probe_unit dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    #500ms;
    $display("FAIL");
    $finish;
  end

  task automatic report(string what);
    fail_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // monitor: requests and results sampled at the edge
  always @(posedge clk) begin
    join_result_t r;
    string msg;
    if (!rst) begin
      if (start && !busy) table_sb.note_request(command, join_key, payload_offset);
      if (result_valid) begin
        r.kind = kind; r.status = status; r.offset = matched_offset;
        r.key = matched_key; r.last = last; r.total = join_total;
        msg = table_sb.check_result(r);
        if (msg != "") report(msg);
      end
    end
  end

  // present one request and hold it until taken
  task automatic send(logic [1:0] cmd, logic [31:0] key, logic [23:0] off);
    if (!quiet && $urandom_range(99) < 10) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1;
    command <= cmd;
    join_key <= key;
    payload_offset <= off;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
  endtask

  task automatic wait_idle();
    start <= 0;
    forever begin
      @(negedge clk);
      if (!busy && table_sb.owed.size() == 0) break;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_buckets(logic [10:0] n);
    wait_idle();
    @(posedge clk);
    psel <= 1; pwrite <= 1; paddr <= 2'd0;
    pwdata <= {11'($urandom_range(0, 2047)), 10'd0, n};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    table_sb.bucket_reg = n;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    return ($urandom_range(9) < 8) ? key_pool[4'($urandom_range(15))] : $urandom;
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (key_pool[i]) key_pool[i] = $urandom_range(0, 40);
    key_pool[0] = 32'hFFFF_FFFF;
    key_pool[1] = 32'h0;

    // directed: extremes, unused code, probe misses, reset bucket count
    send(CMD_PROBE, 32'h0, 24'h0);
    send(CMD_BUILD, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send(CMD_BUILD, 32'h0, 24'h0);
    send(CMD_BUILD, 32'hFFFF_FFFF, 24'h5A5A5A);
    send(CMD_PROBE, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send(CMD_PROBE, 32'h0, 24'h0);
    send(CMD_PROBE, 32'd1023, 24'h0);
    send(2'd3, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send(CMD_CLEAR, 32'h0, 24'h0);
    send(CMD_PROBE, 32'hFFFF_FFFF, 24'h0);

    // zero bucket count acts as one; chains built before stay put
    set_buckets(11'd0);
    send(CMD_BUILD, 32'd7, 24'h1);
    send(CMD_BUILD, 32'd9, 24'h2);
    set_buckets(11'd2047);
    send(CMD_PROBE, 32'd7, 24'h0);
    send(CMD_BUILD, 32'd1031, 24'h3);
    send(CMD_PROBE, 32'd1031, 24'h0);

    // truncation: more matches than the cap in one chain
    set_buckets(11'd1);
    send(CMD_CLEAR, 32'h0, 24'h0);
    for (int i = 0; i < MAX_MATCHES_DEF + 2; i++) send(CMD_BUILD, 32'd42, 24'(i));
    send(CMD_PROBE, 32'd42, 24'h0);
    send(CMD_BUILD, 32'd43, 24'h0);
    send(CMD_PROBE, 32'd43, 24'h0);

    // short chains over many buckets, then a hit and a miss
    set_buckets(11'd1024);
    send(CMD_CLEAR, 32'h0, 24'h0);
    quiet = 1;
    for (int i = 0; i < 16; i++) send(CMD_BUILD, 32'(i), 24'($urandom));
    quiet = 0;
    send(CMD_BUILD, $urandom, 24'($urandom));
    send(CMD_BUILD, 32'd5, 24'h77);
    send(CMD_PROBE, 32'd5, 24'h0);
    send(CMD_PROBE, 32'd1029, 24'h0);
    send(CMD_CLEAR, 32'h0, 24'h0);

    // random phases over several bucket counts, one with no idling
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_buckets(11'd1);
        1: set_buckets(11'd7);
        2: set_buckets(11'd1024);
        3: set_buckets(11'($urandom_range(2, 64)));
        default: set_buckets(11'($urandom_range(0, 2047)));
      endcase
      quiet = (ph == 2);
      for (int i = 0; i < 60; i++) begin
        case ($urandom_range(99)) inside
          [0:1]:   send(CMD_CLEAR, $urandom, 24'($urandom));
          [2:3]:   send(2'd3, $urandom, 24'($urandom));
          [4:51]:  send(CMD_BUILD, pick_key(), 24'($urandom));
          default: send(CMD_PROBE, pick_key(), 24'($urandom));
        endcase
      end
    end
    quiet = 0;

    wait_idle();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && table_sb.owed.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
